@@ sv/cbms_pkg.sv @@
// ----------------------------------------------------------------------------
// cbms_pkg
// Shared types and constants for the cubic Bezier motion stepper.
// ----------------------------------------------------------------------------
package cbms_pkg;

    localparam int DUR_BITS  = 24;
    localparam int TIME_BITS = 32;
    localparam int STEP_BITS = 16;
    localparam int KIND_BITS = 2;
    localparam int IDX_BITS  = 3;

    typedef logic [KIND_BITS-1:0] kind_t;
    localparam kind_t KIND_TICK  = 2'd0;
    localparam kind_t KIND_START = 2'd1;
    localparam kind_t KIND_STOP  = 2'd2;

    typedef logic [IDX_BITS-1:0] reg_idx_t;
    localparam reg_idx_t REG_CTRL1_X  = 3'd0;
    localparam reg_idx_t REG_CTRL1_Y  = 3'd1;
    localparam reg_idx_t REG_CTRL2_X  = 3'd2;
    localparam reg_idx_t REG_CTRL2_Y  = 3'd3;
    localparam reg_idx_t REG_END_DX   = 3'd4;
    localparam reg_idx_t REG_END_DY   = 3'd5;
    localparam reg_idx_t REG_DURATION = 3'd6;

    localparam logic [DUR_BITS-1:0] DUR_RESET = 24'd1000;

endpackage

@@ sv/cbms_div.sv @@
// ----------------------------------------------------------------------------
// cbms_div
// Restoring divider, one quotient bit per cycle: q = floor(num*2^T/den),
// num <= den, so q <= 2^T.
// ----------------------------------------------------------------------------
module cbms_div #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cbms_pkg::DUR_BITS-1:0]  num,
    input  logic [cbms_pkg::DUR_BITS-1:0]  den,
    output logic                           done,
    output logic [T_FRAC_BITS:0]           quot
);
    localparam int DW = cbms_pkg::DUR_BITS;
    localparam int CW = $clog2(T_FRAC_BITS + 1);
    localparam logic [CW-1:0] LAST = CW'(T_FRAC_BITS - 1);

    logic [DW-1:0]          rem_reg, rem_next;
    logic [T_FRAC_BITS:0]   q_reg, q_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   run_reg, run_next;
    logic                   done_reg, done_next;
    logic [DW:0]            rem2;
    logic                   ge;

    assign rem2 = {rem_reg, 1'b0};
    assign ge   = rem2 >= {1'b0, den};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            // equal operands give exactly 1.0, remainder zero
            rem_next = (num == den) ? '0 : num;
            q_next   = {{T_FRAC_BITS{1'b0}}, num == den};
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = ge ? DW'(rem2 - {1'b0, den}) : rem2[DW-1:0];
            q_next   = {q_reg[T_FRAC_BITS-1:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ sv/cbms_mul.sv @@
// ----------------------------------------------------------------------------
// cbms_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module cbms_mul #(
    parameter int AW = 19,
    parameter int BW = 24
) (
    input  logic                      aclk,
    input  logic signed [AW-1:0]      op_a,
    input  logic signed [BW-1:0]      op_b,
    output logic signed [AW+BW-1:0]   prod
);
    logic signed [AW+BW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= (AW+BW)'(op_a) * (AW+BW)'(op_b);
    end

    assign prod = prod_reg;

endmodule

@@ sv/cubic_bezier_motion_stepper.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_motion_stepper
// Steps a point along a cubic Bezier curve offset from a start position.
// ----------------------------------------------------------------------------
//  channel | ports                         | dir | notes
//  s_      | s_valid/s_ready, kind..begin_y | in  | one beat per command
//  m_      | m_valid/m_ready, pos..stopped  | out | one beat per command
//  cfg_    | cfg_we, cfg_index, cfg_wdata   | in  | write only, no wait
//
// Start, stop and halted ticks go from idle straight to the result state;
// a tick past the end first passes the range check. A live tick also runs
// the restoring divider (one quotient bit per cycle) and then eleven passes
// through the one shared multiplier, before the position and velocity states.
// Reset is synchronous, active low; the block comes up halted with
// duration 1000. A stalled result holds the block in its final state until
// the beat is taken; s_ready is high only when idle.
module cubic_bezier_motion_stepper #(
    parameter int COORD_BITS  = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // config port
    input  logic                                    cfg_we,
    input  logic [cbms_pkg::IDX_BITS-1:0]           cfg_index,
    input  logic [((COORD_BITS > 24) ? COORD_BITS : 24)-1:0] cfg_wdata,
    // command channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [cbms_pkg::KIND_BITS-1:0]          s_kind,
    input  logic [cbms_pkg::STEP_BITS-1:0]          s_step_time,
    input  logic signed [COORD_BITS-1:0]            s_begin_x,
    input  logic signed [COORD_BITS-1:0]            s_begin_y,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [COORD_BITS-1:0]            m_pos_x,
    output logic signed [COORD_BITS-1:0]            m_pos_y,
    output logic signed [COORD_BITS-1:0]            m_vel_x,
    output logic signed [COORD_BITS-1:0]            m_vel_y,
    output logic                                    m_arrived,
    output logic                                    m_stopped
);
    localparam int C   = COORD_BITS;
    localparam int T   = T_FRAC_BITS;
    localparam int DW  = cbms_pkg::DUR_BITS;
    localparam int EW  = cbms_pkg::TIME_BITS;
    localparam int AW  = T + 3;                    // coefficients, < 3*2^T
    localparam int BW  = (C > T + 2) ? C : T + 2;  // coords or t/u
    localparam int PW  = AW + BW;
    localparam int ACW = PW + 2;                   // three-term sum
    localparam int SW  = 4;                        // mul step counter

    localparam logic [SW-1:0] STEP_LAST = 4'd12;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CHK  = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_POS  = 7'b0010000,
        ST_VEL  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    // ---------------- configuration ----------------
    logic signed [C-1:0] c1x_reg, c1y_reg, c2x_reg, c2y_reg, ex_reg, ey_reg;
    logic [DW-1:0]       dur_reg;
    logic [DW-1:0]       dur_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1x_reg <= '0;
            c1y_reg <= '0;
            c2x_reg <= '0;
            c2y_reg <= '0;
            ex_reg  <= '0;
            ey_reg  <= '0;
            dur_reg <= cbms_pkg::DUR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                cbms_pkg::REG_CTRL1_X:  c1x_reg <= cfg_wdata[C-1:0];
                cbms_pkg::REG_CTRL1_Y:  c1y_reg <= cfg_wdata[C-1:0];
                cbms_pkg::REG_CTRL2_X:  c2x_reg <= cfg_wdata[C-1:0];
                cbms_pkg::REG_CTRL2_Y:  c2y_reg <= cfg_wdata[C-1:0];
                cbms_pkg::REG_END_DX:   ex_reg  <= cfg_wdata[C-1:0];
                cbms_pkg::REG_END_DY:   ey_reg  <= cfg_wdata[C-1:0];
                cbms_pkg::REG_DURATION: dur_reg <= cfg_wdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // zero duration behaves as one
    assign dur_eff = (dur_reg == '0) ? DW'(1) : dur_reg;

    // ---------------- saturation helpers ----------------
    function automatic logic signed [C-1:0] sat_wide(input logic signed [ACW-1:0] v);
        logic [ACW-C:0] top;
        logic signed [C-1:0] r;
        top = v[ACW-1:C-1];
        if (top == '0 || top == '1) r = v[C-1:0];
        else if (v[ACW-1])          r = {1'b1, {(C-1){1'b0}}};
        else                        r = {1'b0, {(C-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [C-1:0] sat_diff(input logic signed [C-1:0] a,
                                                     input logic signed [C-1:0] b);
        logic signed [C:0] d;
        logic signed [C-1:0] r;
        d = (C+1)'(a) - (C+1)'(b);
        if (d[C] == d[C-1]) r = d[C-1:0];
        else if (d[C])      r = {1'b1, {(C-1){1'b0}}};
        else                r = {1'b0, {(C-1){1'b1}}};
        return r;
    endfunction

    // ---------------- state ----------------
    state_t              state_reg, state_next;
    logic [EW-1:0]       elapsed_reg, elapsed_next;
    logic signed [C-1:0] org_x_reg, org_x_next, org_y_reg, org_y_next;
    logic signed [C-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [C-1:0] spd_x_reg, spd_x_next, spd_y_reg, spd_y_next;
    logic signed [C-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic                halt_reg, halt_next;
    logic                arr_reg, arr_next;
    logic [SW-1:0]       step_reg, step_next;
    logic [T:0]          t_reg, t_next, u_reg, u_next;
    logic signed [AW-1:0] su_reg, su_next, st_reg, st_next;
    logic signed [AW-1:0] k1_reg, k1_next, k2_reg, k2_next, k3_reg, k3_next;
    logic signed [ACW-1:0] accx_reg, accx_next, accy_reg, accy_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic signed [C-1:0] o_px_reg, o_py_reg, o_vx_reg, o_vy_reg;
    logic                o_arr_reg, o_stop_reg;
    logic                out_load;

    // ---------------- shared units ----------------
    logic                 div_start;
    logic                 div_done;
    logic [T:0]           div_q;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW+1:0] prod3;
    logic signed [PW+1:0] prod3_sh;
    logic signed [PW-1:0] prod_sh;

    cbms_div #(.T_FRAC_BITS(T)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (elapsed_reg[DW-1:0]),
        .den     (dur_eff),
        .done    (div_done),
        .quot    (div_q)
    );

    cbms_mul #(.AW(AW), .BW(BW)) u_mul (
        .aclk  (aclk),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (prod)
    );

    // 3*x products for the middle Bernstein terms
    assign prod3    = (PW+2)'(prod) + ((PW+2)'(prod) <<< 1);
    assign prod3_sh = prod3 >>> T;
    assign prod_sh  = prod >>> T;

    // operand select: one product issued per step, consumed the step after
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd1:    begin mul_a = AW'(u_reg);  mul_b = BW'(u_reg); end
            4'd2:    begin mul_a = AW'(t_reg);  mul_b = BW'(t_reg); end
            4'd3:    begin mul_a = su_reg;      mul_b = BW'(t_reg); end
            4'd4:    begin mul_a = st_reg;      mul_b = BW'(u_reg); end
            4'd5:    begin mul_a = st_reg;      mul_b = BW'(t_reg); end
            4'd6:    begin mul_a = k1_reg;      mul_b = BW'(c1x_reg); end
            4'd7:    begin mul_a = k1_reg;      mul_b = BW'(c1y_reg); end
            4'd8:    begin mul_a = k2_reg;      mul_b = BW'(c2x_reg); end
            4'd9:    begin mul_a = k2_reg;      mul_b = BW'(c2y_reg); end
            4'd10:   begin mul_a = k3_reg;      mul_b = BW'(ex_reg); end
            4'd11:   begin mul_a = k3_reg;      mul_b = BW'(ey_reg); end
            default: begin mul_a = '0;          mul_b = '0; end
        endcase
    end

    // ---------------- sequencer ----------------
    logic [EW:0]           esum;
    logic signed [ACW-1:0] half;
    logic signed [ACW-1:0] vx, vy;

    assign esum = {1'b0, elapsed_reg} + (EW+1)'(s_step_time);
    assign half = ACW'(1) <<< (T - 1);
    assign vx   = (accx_reg + half) >>> T;
    assign vy   = (accy_reg + half) >>> T;

    assign s_ready  = (state_reg == ST_IDLE) && aresetn;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        org_x_next   = org_x_reg;
        org_y_next   = org_y_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        spd_x_next   = spd_x_reg;
        spd_y_next   = spd_y_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        halt_next    = halt_reg;
        arr_next     = arr_reg;
        step_next    = step_reg;
        t_next       = t_reg;
        u_next       = u_reg;
        su_next      = su_reg;
        st_next      = st_reg;
        k1_next      = k1_reg;
        k2_next      = k2_reg;
        k3_next      = k3_reg;
        accx_next    = accx_reg;
        accy_next    = accy_reg;
        div_start    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    arr_next   = 1'b0;
                    state_next = ST_DONE;
                    if (s_kind == cbms_pkg::KIND_START) begin
                        org_x_next   = s_begin_x;
                        org_y_next   = s_begin_y;
                        cur_x_next   = s_begin_x;
                        cur_y_next   = s_begin_y;
                        spd_x_next   = '0;
                        spd_y_next   = '0;
                        elapsed_next = '0;
                        halt_next    = 1'b0;
                    end else if (s_kind == cbms_pkg::KIND_STOP) begin
                        halt_next = 1'b1;
                    end else if (s_kind == cbms_pkg::KIND_TICK && !halt_reg) begin
                        elapsed_next = esum[EW] ? '1 : esum[EW-1:0];
                        state_next   = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                if (elapsed_reg > EW'(dur_eff)) begin
                    arr_next   = 1'b1;
                    spd_x_next = '0;
                    spd_y_next = '0;
                    state_next = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    t_next     = div_q;
                    u_next     = (T+1)'(1) << T;
                    u_next     = u_next - div_q;
                    accx_next  = '0;
                    accy_next  = '0;
                    step_next  = 4'd1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd2:    su_next = AW'(prod_sh);
                    4'd3:    st_next = AW'(prod_sh);
                    4'd4:    k1_next = AW'(prod3_sh);
                    4'd5:    k2_next = AW'(prod3_sh);
                    4'd6:    k3_next = AW'(prod_sh);
                    4'd7, 4'd9, 4'd11: accx_next = accx_reg + ACW'(prod);
                    4'd8, 4'd10, 4'd12: accy_next = accy_reg + ACW'(prod);
                    default: ;
                endcase
                if (step_reg == STEP_LAST) begin
                    step_next  = '0;
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                nx_next    = sat_wide(vx + ACW'(org_x_reg));
                ny_next    = sat_wide(vy + ACW'(org_y_reg));
                state_next = ST_VEL;
            end
            ST_VEL: begin
                spd_x_next = sat_diff(nx_reg, cur_x_reg);
                spd_y_next = sat_diff(ny_reg, cur_y_reg);
                cur_x_next = nx_reg;
                cur_y_next = ny_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            org_x_reg   <= '0;
            org_y_reg   <= '0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            spd_x_reg   <= '0;
            spd_y_reg   <= '0;
            halt_reg    <= 1'b1;
            arr_reg     <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            org_x_reg   <= org_x_next;
            org_y_reg   <= org_y_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            spd_x_reg   <= spd_x_next;
            spd_y_reg   <= spd_y_next;
            halt_reg    <= halt_next;
            arr_reg     <= arr_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
        // datapath, no reset needed
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        su_reg   <= su_next;
        st_reg   <= st_next;
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
        k3_reg   <= k3_next;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
        if (out_load) begin
            o_px_reg   <= cur_x_reg;
            o_py_reg   <= cur_y_reg;
            o_vx_reg   <= spd_x_reg;
            o_vy_reg   <= spd_y_reg;
            o_arr_reg  <= arr_reg;
            o_stop_reg <= halt_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pos_x   = o_px_reg;
    assign m_pos_y   = o_py_reg;
    assign m_vel_x   = o_vx_reg;
    assign m_vel_y   = o_vy_reg;
    assign m_arrived = o_arr_reg;
    assign m_stopped = o_stop_reg;

endmodule
